@@ rtl/lcpd_pkg.sv @@
// ---------------------------------------------------------------------------
// lcpd_pkg
// Types, constants and the frame remap shared by the LED crossfade driver.
// ---------------------------------------------------------------------------
package lcpd_pkg;

    localparam int DISPLAY_BYTES = 16;
    localparam int FRAME_BITS    = DISPLAY_BYTES * 8;
    localparam int RES_DEPTH     = 4;
    localparam int RES_PTR_W     = $clog2(RES_DEPTH);
    localparam int RES_CNT_W     = $clog2(RES_DEPTH + 1);

    localparam logic [7:0]  PWM_PERIOD_RST  = 8'd41;
    localparam logic [15:0] TOCK_PERIOD_RST = 16'd311;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_WRITE    = 2'd1,
        REQ_FADE_IN  = 2'd2,
        REQ_FADE_OUT = 2'd3
    } req_type_t;

    typedef enum logic {
        REG_PWM_PERIOD  = 1'b0,
        REG_TOCK_PERIOD = 1'b1
    } reg_index_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [DISPLAY_BYTES-1:0] image_t;

    typedef struct packed {
        req_type_t  req;
        logic       image_sel;
        logic [3:0] byte_index;
        byte_t      byte_value;
    } request_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  blank;
        logic                  last;
    } result_t;

    // Each driver chip takes a byte pair: swap nibbles into the even byte,
    // bit-reversed halves into the odd byte.
    function automatic logic [FRAME_BITS-1:0] remap(input image_t buf_in);
        image_t d;
        byte_t  a;
        byte_t  b;
        for (int c = 0; c < DISPLAY_BYTES / 2; c++)
        begin
            a = buf_in[2*c];
            b = buf_in[2*c+1];
            d[2*c]   = {b[3:0], a[7:4]};
            d[2*c+1] = {a[0], a[1], a[2], a[3], b[4], b[5], b[6], b[7]};
        end
        return d;
    endfunction

endpackage

@@ rtl/led_crossfade_pwm_driver_core.sv @@
// ---------------------------------------------------------------------------
// led_crossfade_pwm_driver_core
// PWM crossfade between two 16-byte LED images with remapped frame output.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request item per accept:
//   a PWM tick, an image byte write, or a fade in / fade out start.
//   Output channel (out_valid / out_stall) carries display updates; a tick
//   gives zero, one or two of them, the final one flagged by last_of_tick.
//   Writes and fade starts give no output item.
//   The APB port sets pwm_period (0x0) and tock_period (0x4); write only
//   while the block is idle.
// Order: an accepted item is held in the input register and processed once
//   the result queue has room for two updates; its output items are written
//   to the queue and count_reg, and out_valid follows from count_reg.
// Throughput: one item per cycle while the four-entry result queue has room
//   for two items; the queue drains one item per cycle unless out_stall,
//   so sustained two-update ticks outpace it and stall the input.
// Reset: counters, fade flags, images and shown buffer clear to zero,
//   registers return to 41 and 311; no clearing pass is needed.
// Stall: a stalled output item holds; no room for two raises in_stall.
// ---------------------------------------------------------------------------
module led_crossfade_pwm_driver_core
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        image_sel,
    input  logic [3:0]  byte_index,
    input  logic [7:0]  byte_value,
    // display update channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] frame_low,
    output logic [63:0] frame_high,
    output logic        is_blank,
    output logic        last_of_tick,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [7:0]  pwm_period_reg;
    logic [15:0] tock_period_reg;
    logic        cfg_we;
    lcpd_pkg::reg_index_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_sel = lcpd_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg  <= lcpd_pkg::PWM_PERIOD_RST;
            tock_period_reg <= lcpd_pkg::TOCK_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                lcpd_pkg::REG_PWM_PERIOD:  pwm_period_reg  <= pwdata[7:0];
                lcpd_pkg::REG_TOCK_PERIOD: tock_period_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            lcpd_pkg::REG_PWM_PERIOD:  prdata = {24'd0, pwm_period_reg};
            lcpd_pkg::REG_TOCK_PERIOD: prdata = {16'd0, tock_period_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // input register
    logic                in_full_reg;
    lcpd_pkg::request_t  in_item_reg;
    logic                proc_go;
    logic                in_accept;

    logic [lcpd_pkg::RES_CNT_W-1:0] count_reg;
    logic [lcpd_pkg::RES_CNT_W-1:0] count_next;

    // process only when the queue can take two updates
    assign proc_go   = in_full_reg &&
                       (count_reg <= lcpd_pkg::RES_CNT_W'(lcpd_pkg::RES_DEPTH - 2));
    assign in_stall  = in_full_reg && !proc_go;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept || proc_go)
        begin
            in_full_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.req        <= lcpd_pkg::req_type_t'(req_type);
            in_item_reg.image_sel  <= image_sel;
            in_item_reg.byte_index <= byte_index;
            in_item_reg.byte_value <= byte_value;
        end
    end

    // driver state
    logic [7:0]  pwm_timer_reg,  pwm_timer_next;
    logic [7:0]  dim_level_reg,  dim_level_next;
    logic        first_phase_reg, first_phase_next;
    logic        fading_in_reg,  fading_in_next;
    logic        fading_out_reg, fading_out_next;
    logic [15:0] prescale_reg,   prescale_next;
    lcpd_pkg::image_t image_one_reg, image_one_next;
    lcpd_pkg::image_t image_two_reg, image_two_next;
    lcpd_pkg::image_t shown_reg,     shown_next;

    logic        is_tick;
    logic [15:0] prescale_dec;
    logic [7:0]  level_in;
    logic [7:0]  level_out;
    logic        emit_a, emit_b;
    logic        blank_a, blank_b;
    logic [lcpd_pkg::FRAME_BITS-1:0] drive_frame;
    lcpd_pkg::result_t res0, res1;
    logic [1:0]  n_push;

    assign is_tick      = (in_item_reg.req == lcpd_pkg::REQ_TICK);
    assign prescale_dec = (prescale_reg != 16'd0) ? prescale_reg - 16'd1 : 16'd0;
    assign drive_frame  = lcpd_pkg::remap(shown_reg);

    always_comb
    begin
        // updates come from the old timer and level
        if (first_phase_reg)
        begin
            emit_a  = (dim_level_reg == pwm_timer_reg) && (dim_level_reg != 8'd0);
            blank_a = 1'b0;
            emit_b  = (pwm_timer_reg == 8'd0);
            blank_b = 1'b1;
        end
        else
        begin
            emit_a  = (dim_level_reg == pwm_timer_reg);
            blank_a = 1'b1;
            emit_b  = (pwm_timer_reg == 8'd0) && (dim_level_reg < pwm_period_reg);
            blank_b = 1'b0;
        end

        n_push = 2'd0;
        if (proc_go && is_tick)
        begin
            n_push = {1'b0, emit_a} + {1'b0, emit_b};
        end

        res0.blank = emit_a ? blank_a : blank_b;
        res0.frame = res0.blank ? '0 : drive_frame;
        res0.last  = !(emit_a && emit_b);
        res1.blank = blank_b;
        res1.frame = blank_b ? '0 : drive_frame;
        res1.last  = 1'b1;
    end

    always_comb
    begin
        pwm_timer_next   = pwm_timer_reg;
        dim_level_next   = dim_level_reg;
        first_phase_next = first_phase_reg;
        fading_in_next   = fading_in_reg;
        fading_out_next  = fading_out_reg;
        prescale_next    = prescale_reg;
        image_one_next   = image_one_reg;
        image_two_next   = image_two_reg;
        shown_next       = shown_reg;
        level_in         = dim_level_reg;
        level_out        = dim_level_reg;

        if (proc_go)
        begin
            case (in_item_reg.req)
                lcpd_pkg::REQ_WRITE:
                begin
                    if (in_item_reg.image_sel)
                        image_two_next[in_item_reg.byte_index] = in_item_reg.byte_value;
                    else
                        image_one_next[in_item_reg.byte_index] = in_item_reg.byte_value;
                end
                lcpd_pkg::REQ_FADE_IN:  fading_in_next  = 1'b1;
                lcpd_pkg::REQ_FADE_OUT: fading_out_next = 1'b1;
                lcpd_pkg::REQ_TICK:
                begin
                    if (pwm_timer_reg == 8'd0)
                    begin
                        pwm_timer_next   = pwm_period_reg;
                        first_phase_next = !first_phase_reg;
                        shown_next       = first_phase_reg ? image_one_reg : image_two_reg;
                    end
                    else
                    begin
                        pwm_timer_next = pwm_timer_reg - 8'd1;
                    end

                    if (prescale_dec == 16'd0)
                    begin
                        prescale_next = tock_period_reg;
                        // in step first, then out step on its result
                        if (fading_in_reg)
                        begin
                            if (dim_level_reg != 8'hFF)
                                level_in = dim_level_reg + 8'd1;
                            if (level_in >= pwm_period_reg)
                                fading_in_next = 1'b0;
                        end
                        level_out = level_in;
                        if (fading_out_reg)
                        begin
                            if (level_in != 8'd0)
                                level_out = level_in - 8'd1;
                            if (level_out == 8'd0)
                                fading_out_next = 1'b0;
                        end
                        dim_level_next = level_out;
                    end
                    else
                    begin
                        prescale_next = prescale_dec;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_timer_reg   <= 8'd0;
            dim_level_reg   <= 8'd0;
            first_phase_reg <= 1'b0;
            fading_in_reg   <= 1'b0;
            fading_out_reg  <= 1'b0;
            prescale_reg    <= 16'd0;
            image_one_reg   <= '0;
            image_two_reg   <= '0;
            shown_reg       <= '0;
        end
        else
        begin
            pwm_timer_reg   <= pwm_timer_next;
            dim_level_reg   <= dim_level_next;
            first_phase_reg <= first_phase_next;
            fading_in_reg   <= fading_in_next;
            fading_out_reg  <= fading_out_next;
            prescale_reg    <= prescale_next;
            image_one_reg   <= image_one_next;
            image_two_reg   <= image_two_next;
            shown_reg       <= shown_next;
        end
    end

    // result queue: two writes, one read per cycle unless out_stall
    lcpd_pkg::result_t res_mem [lcpd_pkg::RES_DEPTH];
    logic [lcpd_pkg::RES_PTR_W-1:0] wptr_reg, rptr_reg;
    logic pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign count_next = count_reg + lcpd_pkg::RES_CNT_W'(n_push)
                        - lcpd_pkg::RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            res_mem[wptr_reg] <= emit_a ? res0 : res1;
        if (n_push == 2'd2)
            res_mem[wptr_reg + lcpd_pkg::RES_PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + lcpd_pkg::RES_PTR_W'(n_push);
            if (pop)
                rptr_reg <= rptr_reg + lcpd_pkg::RES_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign frame_low    = res_mem[rptr_reg].frame[63:0];
    assign frame_high   = res_mem[rptr_reg].frame[127:64];
    assign is_blank     = res_mem[rptr_reg].blank;
    assign last_of_tick = res_mem[rptr_reg].last;

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lcpd_pkg::RES_CNT_W'(lcpd_pkg::RES_DEPTH))
        else $error("result queue overflow");

    a_room_for_two: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> (count_reg <= lcpd_pkg::RES_CNT_W'(lcpd_pkg::RES_DEPTH - 2)))
        else $error("push without room");

    a_wrap_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && is_tick && pwm_timer_reg == 8'd0)
        |=> (first_phase_reg != $past(first_phase_reg)))
        else $error("phase did not toggle on timer wrap");

    a_blank_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_blank) |-> (frame_low == 64'd0 && frame_high == 64'd0))
        else $error("blank update carries frame data");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_full_reg)
        else $error("input register dropped a stalled item");

endmodule
